// ===== sv/triggered_capture_ring_buffer_unit_assert.svh =====
// Assertion macros used by the capture buffer checker.
`ifndef TRIGGERED_CAPTURE_RING_BUFFER_UNIT_ASSERT_SVH
`define TRIGGERED_CAPTURE_RING_BUFFER_UNIT_ASSERT_SVH

// Clocked check, quiet while reset is asserted.
`define TRCB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check, also evaluated through reset.
`define TRCB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/trcb_pkg.sv =====
// Shared constants, codes and types of the triggered capture buffer.
package trcb_pkg;

    localparam int TRCB_DEPTH     = 1024;
    localparam int TRCB_CHANNELS  = 8;
    localparam int TRCB_WORD_BITS = 32;

    localparam int SIZE_BITS = 11;
    localparam int POST_BITS = 11;
    localparam int TICK_BITS = 16;
    localparam int CMD_BITS  = 3;
    localparam int ROW_OUT_BITS = 10;
    localparam int SAMPLE_BITS  = 32;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_RUN     = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_HALT    = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_TRIGGER = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_READ    = 3'd4;

    // Capture states, also used for the host request
    localparam logic [1:0] ST_HALTED    = 2'd0;
    localparam logic [1:0] ST_RUNNING   = 2'd1;
    localparam logic [1:0] ST_ACQUIRING = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_RING_ROWS   = 2'd0;
    localparam logic [1:0] CFG_POST_FRAMES = 2'd1;
    localparam logic [1:0] CFG_TICK_DIV    = 2'd2;

    typedef struct packed {
        logic [1:0]              scope_state;
        logic [ROW_OUT_BITS-1:0] oldest_index;
        logic [ROW_OUT_BITS-1:0] write_index;
    } trcb_status_t;

endpackage

// ===== sv/triggered_capture_ring_buffer_unit.sv =====
// Top level of the triggered capture ring buffer: config registers, pipeline, handshakes.
// Pipeline: two register stages, stage 1 and then the result register, lie between an accepted
// input word and its result word. Throughput: one input word per cycle when in_stall is low;
// one full row write per cycle. Reset: state machine, counters and config registers return to
// their defaults at once; then a clear sweep zeroes the frame memory, one row a cycle, with
// in_stall held high meanwhile. cfg_ready stays high throughout.
module triggered_capture_ring_buffer_unit #(
    parameter int DEPTH     = trcb_pkg::TRCB_DEPTH,
    parameter int CHANNELS  = trcb_pkg::TRCB_CHANNELS,
    parameter int WORD_BITS = trcb_pkg::TRCB_WORD_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [1:0]                             cfg_index,
    input  logic [trcb_pkg::TICK_BITS-1:0]         cfg_data,
    // input word channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [trcb_pkg::CMD_BITS-1:0]          command,
    input  logic [trcb_pkg::SAMPLE_BITS-1:0]       sample_0,
    input  logic [trcb_pkg::SAMPLE_BITS-1:0]       sample_1,
    input  logic [trcb_pkg::SAMPLE_BITS-1:0]       sample_2,
    input  logic [trcb_pkg::SAMPLE_BITS-1:0]       sample_3,
    input  logic [trcb_pkg::SAMPLE_BITS-1:0]       sample_4,
    input  logic [trcb_pkg::SAMPLE_BITS-1:0]       sample_5,
    input  logic [trcb_pkg::SAMPLE_BITS-1:0]       sample_6,
    input  logic [trcb_pkg::SAMPLE_BITS-1:0]       sample_7,
    input  logic [trcb_pkg::ROW_OUT_BITS-1:0]      read_row,
    input  logic [2:0]                             read_channel,
    // result word channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [1:0]                             scope_state,
    output logic [trcb_pkg::ROW_OUT_BITS-1:0]      oldest_index,
    output logic [trcb_pkg::ROW_OUT_BITS-1:0]      write_index,
    output logic [trcb_pkg::SAMPLE_BITS-1:0]       read_data
);
    import trcb_pkg::*;

    localparam int ROW_W    = $clog2(DEPTH);
    localparam int ROW_BITS = CHANNELS * WORD_BITS;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration registers
    logic [SIZE_BITS-1:0] ring_rows_reg;
    logic [POST_BITS-1:0] post_frames_reg;
    logic [TICK_BITS-1:0] tick_div_reg;

    // Handshake and pipeline control
    logic accept;
    logic s1_advance;
    logic clear_busy;

    // Stage 1: status after the step, read bookkeeping
    logic                 s1_valid_reg;
    trcb_status_t         s1_status_reg;
    logic                 s1_hit_reg;
    logic [CH_W-1:0]      s1_channel_reg;

    // Stage 2: result register
    logic                 out_valid_reg;
    trcb_status_t         out_status_reg;
    logic [SAMPLE_BITS-1:0] out_data_reg;

    // Controller and memory hookup
    trcb_status_t         status_next;
    logic                 mem_wr;
    logic [ROW_W-1:0]     wr_row;
    logic [ROW_BITS-1:0]  wr_data;
    logic [ROW_BITS-1:0]  mem_rd_data;
    logic                 rd_en;
    logic                 rd_hit;
    logic [WORD_BITS-1:0] rd_word;
    logic [SAMPLE_BITS-1:0] sample_arr [8];

    // Config writes are taken whenever offered; the host must only write while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_rows_reg   <= SIZE_BITS'(1024);
            post_frames_reg <= POST_BITS'(1024);
            tick_div_reg    <= TICK_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RING_ROWS:   ring_rows_reg   <= cfg_data[SIZE_BITS-1:0];
                CFG_POST_FRAMES: post_frames_reg <= cfg_data[POST_BITS-1:0];
                CFG_TICK_DIV:    tick_div_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1 moves on when the result register is empty or being drained.
    // Hold input off during the clear sweep and while stage 1 is blocked.
    assign s1_advance = !out_valid_reg || !out_stall;
    assign in_stall   = clear_busy || (s1_valid_reg && !s1_advance);
    assign accept     = in_valid && !in_stall;

    // State updates and the frame write happen at accept time, so the next word
    // sees them right away.
    trcb_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_en      (accept),
        .command      (command),
        .ring_rows    (ring_rows_reg),
        .post_frames  (post_frames_reg),
        .tick_divider (tick_div_reg),
        .mem_wr       (mem_wr),
        .wr_row       (wr_row),
        .status_next  (status_next)
    );

    assign sample_arr[0] = sample_0;
    assign sample_arr[1] = sample_1;
    assign sample_arr[2] = sample_2;
    assign sample_arr[3] = sample_3;
    assign sample_arr[4] = sample_4;
    assign sample_arr[5] = sample_5;
    assign sample_arr[6] = sample_6;
    assign sample_arr[7] = sample_7;

    // Pack the frame row, each word cut or extended to the stored width
    for (genvar ch = 0; ch < CHANNELS; ch++)
    begin : g_pack
        assign wr_data[ch*WORD_BITS +: WORD_BITS] = WORD_BITS'(sample_arr[ch]);
    end

    // Out of range rows and channels read as zero
    assign rd_hit = (32'(read_row) < 32'(DEPTH)) && (4'(read_channel) < 4'(CHANNELS));
    assign rd_en  = accept && (command == CMD_READ);

    trcb_frame_mem #(
        .DEPTH     (DEPTH),
        .CHANNELS  (CHANNELS),
        .WORD_BITS (WORD_BITS)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (accept && mem_wr),
        .wr_row     (wr_row),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_row     (ROW_W'(read_row)),
        .rd_data    (mem_rd_data),
        .clear_busy (clear_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Stage 1 payload: capture on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg  <= status_next;
            s1_hit_reg     <= rd_en && rd_hit;
            s1_channel_reg <= rd_hit ? CH_W'(read_channel) : '0;
        end
    end

    // Pick the addressed word from the registered memory row
    assign rd_word = mem_rd_data[s1_channel_reg*WORD_BITS +: WORD_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Result payload: load when stage 1 hands a word over
    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            out_status_reg <= s1_status_reg;
            out_data_reg   <= s1_hit_reg ? SAMPLE_BITS'(rd_word) : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign scope_state  = out_status_reg.scope_state;
    assign oldest_index = out_status_reg.oldest_index;
    assign write_index  = out_status_reg.write_index;
    assign read_data    = out_data_reg;

endmodule

// ===== sv/trcb_ctrl.sv =====
// Capture state machine, tick divider and ring row pointer.
module trcb_ctrl #(
    parameter int DEPTH = trcb_pkg::TRCB_DEPTH,
    localparam int ROW_W = $clog2(DEPTH)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_en,
    input  logic [trcb_pkg::CMD_BITS-1:0]       command,
    input  logic [trcb_pkg::SIZE_BITS-1:0]      ring_rows,
    input  logic [trcb_pkg::POST_BITS-1:0]      post_frames,
    input  logic [trcb_pkg::TICK_BITS-1:0]      tick_divider,
    output logic                                mem_wr,
    output logic [ROW_W-1:0]                    wr_row,
    output trcb_pkg::trcb_status_t              status_next
);
    import trcb_pkg::*;

    localparam int CW = (ROW_W + 1 > SIZE_BITS) ? ROW_W + 1 : SIZE_BITS;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           host_reg, host_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [POST_BITS-1:0] post_reg, post_next;
    logic [TICK_BITS-1:0] tick_reg, tick_next;
    logic [ROW_W-1:0]     oldest_reg, oldest_next;

    logic [CW-1:0]        eff_size;
    logic [CW-1:0]        row_inc;
    logic [ROW_W-1:0]     row_wrap;
    logic [TICK_BITS-1:0] tick_inc;
    logic                 kept;
    logic                 store;

    // Zero size acts as one, sizes beyond the array act as the array
    always_comb
    begin
        if (ring_rows == '0)
        begin
            eff_size = CW'(1);
        end
        else if (CW'(ring_rows) > CW'(DEPTH))
        begin
            eff_size = CW'(DEPTH);
        end
        else
        begin
            eff_size = CW'(ring_rows);
        end
    end

    assign row_inc  = CW'(row_reg) + CW'(1);
    assign row_wrap = (row_inc >= eff_size) ? '0 : ROW_W'(row_inc);
    assign tick_inc = tick_reg + TICK_BITS'(1);

    always_comb
    begin
        state_next  = state_reg;
        host_next   = host_reg;
        row_next    = row_reg;
        post_next   = post_reg;
        tick_next   = tick_reg;
        oldest_next = oldest_reg;
        kept        = 1'b0;
        store       = 1'b0;

        if (item_en)
        begin
            unique case (command)
                CMD_TICK:
                begin
                    if (tick_inc < tick_divider)
                    begin
                        tick_next = tick_inc;
                    end
                    else
                    begin
                        tick_next = '0;
                        kept      = 1'b1;
                    end
                end
                CMD_RUN:     host_next = ST_RUNNING;
                CMD_HALT:    host_next = ST_HALTED;
                CMD_TRIGGER:
                begin
                    if (state_reg == ST_RUNNING)
                    begin
                        host_next = ST_ACQUIRING;
                    end
                end
                default: ;
            endcase
        end

        if (kept)
        begin
            unique case (state_reg)
                ST_HALTED:
                begin
                    row_next = '0;
                    if (host_reg == ST_RUNNING)
                    begin
                        state_next = ST_RUNNING;
                    end
                end
                ST_RUNNING:
                begin
                    if (host_reg == ST_HALTED)
                    begin
                        state_next = ST_HALTED;
                    end
                    if (host_reg == ST_ACQUIRING)
                    begin
                        if (post_frames == '0)
                        begin
                            state_next  = ST_HALTED;
                            oldest_next = row_reg;
                        end
                        else
                        begin
                            state_next = ST_ACQUIRING;
                            post_next  = POST_BITS'(1);
                        end
                    end
                    store = 1'b1;
                end
                ST_ACQUIRING:
                begin
                    if (post_reg == post_frames)
                    begin
                        state_next  = ST_HALTED;
                        oldest_next = row_reg;
                    end
                    else
                    begin
                        post_next = post_reg + POST_BITS'(1);
                        store     = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (store)
        begin
            row_next = row_wrap;
        end
    end

    assign mem_wr = store;
    assign wr_row = row_reg;

    assign status_next.scope_state  = state_next;
    assign status_next.oldest_index = ROW_OUT_BITS'(oldest_next);
    assign status_next.write_index  = ROW_OUT_BITS'(row_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_HALTED;
            host_reg   <= ST_HALTED;
            row_reg    <= '0;
            post_reg   <= '0;
            tick_reg   <= '0;
            oldest_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            host_reg   <= host_next;
            row_reg    <= row_next;
            post_reg   <= post_next;
            tick_reg   <= tick_next;
            oldest_reg <= oldest_next;
        end
    end

endmodule

// ===== sv/trcb_frame_mem.sv =====
// Frame memory: one row per frame, one row write and one row read per cycle, clear sweep.
module trcb_frame_mem #(
    parameter int DEPTH     = trcb_pkg::TRCB_DEPTH,
    parameter int CHANNELS  = trcb_pkg::TRCB_CHANNELS,
    parameter int WORD_BITS = trcb_pkg::TRCB_WORD_BITS,
    localparam int ROW_W    = $clog2(DEPTH),
    localparam int ROW_BITS = CHANNELS * WORD_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [ROW_W-1:0]    wr_row,
    input  logic [ROW_BITS-1:0] wr_data,
    input  logic                rd_en,
    input  logic [ROW_W-1:0]    rd_row,
    output logic [ROW_BITS-1:0] rd_data,
    output logic                clear_busy
);
    import trcb_pkg::*;

    logic [ROW_BITS-1:0] mem [DEPTH];
    logic [ROW_BITS-1:0] rd_data_reg;
    logic                clear_busy_reg;
    logic [ROW_W-1:0]    clear_row_reg;

    logic                we;
    logic [ROW_W-1:0]    waddr;
    logic [ROW_BITS-1:0] wdata;

    // Clear sweep owns the port until every row is zero
    assign we    = clear_busy_reg || wr_en;
    assign waddr = clear_busy_reg ? clear_row_reg : wr_row;
    assign wdata = clear_busy_reg ? '0 : wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_row_reg  <= '0;
        end
        else if (clear_busy_reg)
        begin
            clear_row_reg <= clear_row_reg + ROW_W'(1);
            if (clear_row_reg == ROW_W'(DEPTH - 1))
            begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clear_busy_reg;

endmodule

// ===== sv/trcb_checker.sv =====
// Port-level checker for the capture buffer, bound to the top level.
`include "triggered_capture_ring_buffer_unit_assert.svh"

module trcb_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [1:0]                           scope_state,
    input logic [trcb_pkg::ROW_OUT_BITS-1:0]    oldest_index,
    input logic [trcb_pkg::ROW_OUT_BITS-1:0]    write_index,
    input logic [trcb_pkg::SAMPLE_BITS-1:0]     read_data
);
    import trcb_pkg::*;

    logic [1:0]              last_state_reg;
    logic [ROW_OUT_BITS-1:0] last_first_reg;

    // Track the last delivered result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_state_reg <= ST_HALTED;
            last_first_reg <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            last_state_reg <= scope_state;
            last_first_reg <= oldest_index;
        end
    end

    // Stalled result word holds
    `TRCB_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(scope_state) && $stable(oldest_index) && $stable(write_index) && $stable(read_data), "result word changed while stalled")

    // Clear sweep keeps input off right after reset
    `TRCB_ASSERT(a_clear_after_reset, !$past(rst_n) |-> in_stall, "input taken during clear sweep")

    // A halted machine only moves to running in one step
    `TRCB_ASSERT(a_no_skip_run, out_valid && last_state_reg == ST_HALTED |-> scope_state != ST_ACQUIRING, "halted jumped to acquiring")

    // Oldest row is only recorded on the way into halted
    `TRCB_ASSERT(a_first_on_halt, out_valid && scope_state != ST_HALTED |-> oldest_index == last_first_reg, "oldest index moved outside a halt")

endmodule

bind triggered_capture_ring_buffer_unit trcb_checker u_trcb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .scope_state   (scope_state),
    .oldest_index  (oldest_index),
    .write_index   (write_index),
    .read_data     (read_data)
);
